// ----- rtl/core/mag_pkg.sv -----
`timescale 1ns / 1ps

package mag_pkg;

  // Field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned POS_W  = 31;

  // Default table size
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_JOIN  = 2'd0,
    FUNC_LEAVE = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // Input item
  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   member_id;
    logic [POS_W-1:0]  position;
  } in_t;

  // Result item
  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  upper_id;
    logic [ID_W-1:0]  lower_id;
  } out_t;

  // One table entry, kept sorted by position
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  owner;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic clear_all;
    logic search_rd;
    logic search_upd;
    logic check_rd;
    logic write_owner;
    logic shift_init;
    logic shift_step;
    logic insert;
    logic leave_step;
    logic leave_end;
    logic query_step;
    logic result_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic search_open;
    logic lo_lt_cnt;
    logic pos_eq;
    logic full;
    logic shift_done;
    logic scan_done;
    logic rd_valid;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/mag_ram.sv -----
`timescale 1ns / 1ps

module mag_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mag_datapath.sv -----
`timescale 1ns / 1ps

module mag_datapath #(
  parameter int unsigned TABLE_DEPTH = mag_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mag_pkg::cmd_t  cmd_i,
  output mag_pkg::stat_t stat_o,
  input  mag_pkg::in_t   in_data_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output mag_pkg::out_t  out_data_o
);

  import mag_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // Control state
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rv_q, rv_d;
  logic          out_valid_q, out_valid_d;
  // Walk pointers
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d, wp_q, wp_d;
  logic [AW-1:0] ra_q, ra_d;
  // Item and query payload
  logic [ID_W-1:0]  id_q, id_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] prev_pos_q, prev_pos_d;
  logic [ID_W-1:0]  prev_id_q, prev_id_d;
  logic             prev_ok_q, prev_ok_d;
  logic             have_q, have_d;
  logic [POS_W-1:0] best_gap_q, best_gap_d;
  logic [ID_W-1:0]  best_up_q, best_up_d, best_lo_q, best_lo_d;
  out_t             out_q, out_d;

  // RAM port signals
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rdata;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    idx_dec;
  logic [POS_W-1:0] gap;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign idx_dec = idx_q - CW'(1);
  assign gap     = rdata.pos - prev_pos_q;

  mag_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Status back to the controller
  always_comb begin
    stat_o.search_open = lo_q < hi_q;
    stat_o.lo_lt_cnt   = lo_q < cnt_q;
    stat_o.pos_eq      = rdata.pos == pos_q;
    stat_o.full        = cnt_q == CW'(TABLE_DEPTH);
    stat_o.shift_done  = idx_q == lo_q;
    stat_o.scan_done   = idx_q == cnt_q;
    stat_o.rd_valid    = rv_q;
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // Next-state logic for all datapath registers
  always_comb begin
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    wp_d        = wp_q;
    id_d        = id_q;
    pos_d       = pos_q;
    prev_pos_d  = prev_pos_q;
    prev_id_d   = prev_id_q;
    prev_ok_d   = prev_ok_q;
    have_d      = have_q;
    best_gap_d  = best_gap_q;
    best_up_d   = best_up_q;
    best_lo_d   = best_lo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '{pos: pos_q, owner: id_q};

    // Item transfer: latch fields, reset walk pointers
    if (cmd_i.load_item) begin
      id_d      = in_data_i.member_id;
      pos_d     = in_data_i.position;
      lo_d      = '0;
      hi_d      = cnt_q;
      idx_d     = '0;
      wp_d      = '0;
      prev_ok_d = 1'b0;
      have_d    = 1'b0;
    end
    if (cmd_i.clear_all) begin
      cnt_d = '0;
    end

    // Binary search for the first position not below the item's
    if (cmd_i.search_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid[AW-1:0];
      idx_d   = mid;
    end
    if (cmd_i.search_upd) begin
      if (rdata.pos < pos_q) begin
        lo_d = idx_q + CW'(1);
      end else begin
        hi_d = idx_q;
      end
    end
    if (cmd_i.check_rd) begin
      rd_en   = 1'b1;
      rd_addr = lo_q[AW-1:0];
    end

    // Rename in place, or place a new entry
    if (cmd_i.write_owner || cmd_i.insert) begin
      wr_en   = 1'b1;
      wr_addr = lo_q[AW-1:0];
    end
    if (cmd_i.insert) begin
      cnt_d = cnt_q + CW'(1);
    end

    // Shift the upper part of the table up by one, top first
    if (cmd_i.shift_init) begin
      idx_d = cnt_q;
    end
    if (cmd_i.shift_step) begin
      if (rv_q) begin
        wr_en   = 1'b1;
        wr_addr = ra_q + AW'(1);
        wr_data = rdata;
      end
      if (idx_q != lo_q) begin
        rd_en   = 1'b1;
        rd_addr = idx_dec[AW-1:0];
        idx_d   = idx_dec;
      end
    end

    // Leave: compact the table, dropping the id's entries
    if (cmd_i.leave_step) begin
      if (rv_q && (rdata.owner != id_q)) begin
        wr_en   = 1'b1;
        wr_addr = wp_q[AW-1:0];
        wr_data = rdata;
        wp_d    = wp_q + CW'(1);
      end
      if (idx_q != cnt_q) begin
        rd_en   = 1'b1;
        rd_addr = idx_q[AW-1:0];
        idx_d   = idx_q + CW'(1);
      end
    end
    if (cmd_i.leave_end) begin
      cnt_d = wp_q;
    end

    // Query: walk in position order, keep the smallest gap (last on ties)
    if (cmd_i.query_step) begin
      if (rv_q) begin
        if (prev_ok_q && (!have_q || (gap <= best_gap_q))) begin
          have_d     = 1'b1;
          best_gap_d = gap;
          best_up_d  = rdata.owner;
          best_lo_d  = prev_id_q;
        end
        prev_pos_d = rdata.pos;
        prev_id_d  = rdata.owner;
        prev_ok_d  = 1'b1;
      end
      if (idx_q != cnt_q) begin
        rd_en   = 1'b1;
        rd_addr = idx_q[AW-1:0];
        idx_d   = idx_q + CW'(1);
      end
    end

    // Output register
    if (cmd_i.result_load) begin
      out_valid_d    = 1'b1;
      out_d.found    = have_q;
      out_d.upper_id = have_q ? best_up_q : '0;
      out_d.lower_id = have_q ? best_lo_q : '0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rv_d = rd_en;
  assign ra_d = rd_addr;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    wp_q       <= wp_d;
    ra_q       <= ra_d;
    id_q       <= id_d;
    pos_q      <= pos_d;
    prev_pos_q <= prev_pos_d;
    prev_id_q  <= prev_id_d;
    prev_ok_q  <= prev_ok_d;
    have_q     <= have_d;
    best_gap_q <= best_gap_d;
    best_up_q  <= best_up_d;
    best_lo_q  <= best_lo_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/mag_ctrl.sv -----
`timescale 1ns / 1ps

module mag_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mag_pkg::func_e  in_func_i,
  output logic            in_stall_o,
  input  mag_pkg::stat_t  stat_i,
  output mag_pkg::cmd_t   cmd_o
);

  import mag_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SEARCH     = 4'd1;
  localparam logic [3:0] S_SEARCH_CMP = 4'd2;
  localparam logic [3:0] S_CHECK      = 4'd3;
  localparam logic [3:0] S_CHECK_CMP  = 4'd4;
  localparam logic [3:0] S_SHIFT      = 4'd5;
  localparam logic [3:0] S_INSERT     = 4'd6;
  localparam logic [3:0] S_LEAVE      = 4'd7;
  localparam logic [3:0] S_QUERY      = 4'd8;
  localparam logic [3:0] S_RESULT     = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = state_q != S_IDLE;

  // Sequencer
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          case (in_func_i)
            FUNC_JOIN:  state_d = S_SEARCH;
            FUNC_LEAVE: state_d = S_LEAVE;
            FUNC_QUERY: state_d = S_QUERY;
            FUNC_CLEAR: cmd_o.clear_all = 1'b1;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (stat_i.search_open) begin
          cmd_o.search_rd = 1'b1;
          state_d         = S_SEARCH_CMP;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_SEARCH_CMP: begin
        cmd_o.search_upd = 1'b1;
        state_d          = S_SEARCH;
      end
      S_CHECK: begin
        if (stat_i.lo_lt_cnt) begin
          cmd_o.check_rd = 1'b1;
          state_d        = S_CHECK_CMP;
        end else if (stat_i.full) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end
      end
      S_CHECK_CMP: begin
        if (stat_i.pos_eq) begin
          cmd_o.write_owner = 1'b1;
          state_d           = S_IDLE;
        end else if (stat_i.full) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_done && !stat_i.rd_valid) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = S_IDLE;
      end
      S_LEAVE: begin
        cmd_o.leave_step = 1'b1;
        if (stat_i.scan_done && !stat_i.rd_valid) begin
          cmd_o.leave_end = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_QUERY: begin
        cmd_o.query_step = 1'b1;
        if (stat_i.scan_done && !stat_i.rd_valid) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/min_adjacent_gap_tracker_core.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Payload              | Handshake
// ---------+-----------+----------------------+-----------------------------
// in       | input     | in_data_i  (in_t)    | in_valid_i / in_stall_o
// out      | output    | out_data_o (out_t)   | out_valid_o / out_stall_i
//
// Entries sit sorted by position in one table RAM with a registered read.
// A leave or a query scans every entry; a join runs a binary search and then, for a new
// position, moves the entries at and above the insertion point up by one.
// After reset the table is empty; a fill count stands in for a clearing pass.
// A query result waits in the output register while the next item is taken;
// only a following query's result stalls on it, and then so does the input.

module min_adjacent_gap_tracker_core #(
  parameter int unsigned TABLE_DEPTH = mag_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mag_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mag_pkg::out_t out_data_o
);

  import mag_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mag_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

// Tracks the member set and predicts the closest neighbor pair per query
class line_roster;
  bit                            held [mag_pkg::TABLE_DEPTH_DEF];
  logic [mag_pkg::POS_W-1:0]     spot [mag_pkg::TABLE_DEPTH_DEF];
  logic [mag_pkg::ID_W-1:0]      tag  [mag_pkg::TABLE_DEPTH_DEF];
  mag_pkg::out_t                 pairs_due [$];
  int unsigned                   mismatches;

  function new();
    foreach (held[i]) held[i] = 1'b0;
    mismatches = 0;
  endfunction

  // Rename on a held position, else take the first free slot; full table drops it
  function void join_member(logic [mag_pkg::ID_W-1:0] id, logic [mag_pkg::POS_W-1:0] pos);
    int free_idx;
    free_idx = -1;
    foreach (held[i]) begin
      if (held[i]) begin
        if (spot[i] == pos) begin
          tag[i] = id;
          return;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx >= 0) begin
      held[free_idx] = 1'b1;
      spot[free_idx] = pos;
      tag[free_idx]  = id;
    end
  endfunction

  // Sort members by position, then pick the smallest adjacent gap;
  // ascending scan with <= keeps the tie with the greatest lower position
  function mag_pkg::out_t closest_pair();
    int unsigned               order [$];
    int unsigned               k;
    logic [mag_pkg::POS_W-1:0] gap;
    logic [mag_pkg::POS_W-1:0] best_gap;
    mag_pkg::out_t             res;
    res = '0;
    best_gap = '0;
    foreach (held[i]) begin
      if (held[i]) begin
        k = order.size();
        order.push_back(i);
        while (k > 0 && spot[order[k-1]] > spot[i]) begin
          order[k] = order[k-1];
          k--;
        end
        order[k] = i;
      end
    end
    for (int n = 1; n < order.size(); n++) begin
      gap = spot[order[n]] - spot[order[n-1]];
      if (!res.found || gap <= best_gap) begin
        res.found    = 1'b1;
        best_gap     = gap;
        res.upper_id = tag[order[n]];
        res.lower_id = tag[order[n-1]];
      end
    end
    return res;
  endfunction

  // Apply one accepted input transfer
  function void take_item(mag_pkg::in_t it);
    case (it.func)
      mag_pkg::FUNC_JOIN: join_member(it.member_id, it.position);
      mag_pkg::FUNC_LEAVE: begin
        foreach (held[i]) begin
          if (held[i] && tag[i] == it.member_id) held[i] = 1'b0;
        end
      end
      mag_pkg::FUNC_QUERY: pairs_due.push_back(closest_pair());
      default: begin
        foreach (held[i]) held[i] = 1'b0;
      end
    endcase
  endfunction

  // Compare one output transfer with the oldest predicted pair
  function void check_pair(mag_pkg::out_t got);
    mag_pkg::out_t want;
    if (pairs_due.size() == 0) begin
      $error("unexpected result: found=%0d upper_id=%0d lower_id=%0d",
             got.found, got.upper_id, got.lower_id);
      mismatches++;
      return;
    end
    want = pairs_due.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      mismatches++;
    end
    if (got.upper_id !== want.upper_id) begin
      $error("upper_id: expected %0d, got %0d", want.upper_id, got.upper_id);
      mismatches++;
    end
    if (got.lower_id !== want.lower_id) begin
      $error("lower_id: expected %0d, got %0d", want.lower_id, got.lower_id);
      mismatches++;
    end
  endfunction
endclass

module tb;
  import mag_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  in_t   in_data_i   = '0;
  logic  out_stall_i = 1'b0;
  logic  in_stall_o;
  logic  out_valid_o;
  out_t  out_data_o;

  line_roster  roster = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;

  min_adjacent_gap_tracker_core #(
    .TABLE_DEPTH(TABLE_DEPTH_DEF)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stall: random, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) roster.check_pair(out_data_o);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, until it is taken
  task automatic send_item(in_t it);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    roster.take_item(it);
  endtask

  task automatic put(func_e f, logic [ID_W-1:0] id, logic [POS_W-1:0] pos);
    in_t it;
    it.func      = f;
    it.member_id = id;
    it.position  = pos;
    send_item(it);
  endtask

  // Sender pauses until every predicted pair has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (roster.pairs_due.size() != 0);
  endtask

  // Mostly small ids and clustered positions so that renames, leaves and ties happen
  function automatic in_t rand_item();
    in_t         it;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 45)      it.func = FUNC_JOIN;
    else if (roll < 60) it.func = FUNC_LEAVE;
    else if (roll < 96) it.func = FUNC_QUERY;
    else                it.func = FUNC_CLEAR;
    if ($urandom_range(99, 0) < 70) it.member_id = 8'($urandom_range(15, 0));
    else                            it.member_id = 8'($urandom());
    roll = $urandom_range(99, 0);
    if (roll < 40)      it.position = 31'($urandom_range(63, 0));
    else if (roll < 70) it.position = 31'($urandom_range(127, 0) * 8);
    else if (roll < 90) it.position = 31'($urandom());
    else begin
      case ($urandom_range(3, 0))
        0:       it.position = '0;
        1:       it.position = 31'd1;
        2:       it.position = POS_MAX - 31'd1;
        default: it.position = POS_MAX;
      endcase
    end
    return it;
  endfunction

  // Edge cases on a small set
  task automatic directed();
    put(FUNC_QUERY, 8'h00, '0);            // empty set
    put(FUNC_LEAVE, 8'h42, '0);            // leave on empty set
    put(FUNC_JOIN,  8'h00, '0);
    put(FUNC_QUERY, 8'h00, '0);            // one member only
    put(FUNC_JOIN,  8'hFF, POS_MAX);
    put(FUNC_QUERY, 8'h00, '0);            // widest gap
    put(FUNC_JOIN,  8'hAA, 31'd10);
    put(FUNC_JOIN,  8'h55, 31'd20);
    put(FUNC_JOIN,  8'h07, 31'd30);
    put(FUNC_QUERY, 8'h00, '0);            // three equal gaps
    put(FUNC_JOIN,  8'h33, 31'd20);        // rename held position
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_JOIN,  8'h07, 31'd31);        // same id at a second position
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_LEAVE, 8'h07, '0);            // drops both slots of that id
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_LEAVE, 8'h99, POS_MAX);       // unknown id
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_JOIN,  8'h01, POS_MAX - 31'd1);
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_CLEAR, 8'hFF, POS_MAX);
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_JOIN,  8'h80, 31'd5);
    put(FUNC_QUERY, 8'h00, '0);
  endtask

  // Fill every slot in shuffled order, then joins on a full table
  task automatic fill_table();
    int unsigned      slot_order [TABLE_DEPTH_DEF];
    logic [POS_W-1:0] fill_pos   [TABLE_DEPTH_DEF];
    int unsigned      pick;
    int unsigned      tmp;
    foreach (slot_order[i]) slot_order[i] = i;
    for (int i = TABLE_DEPTH_DEF - 1; i > 0; i--) begin
      pick = $urandom_range(i, 0);
      tmp = slot_order[i];
      slot_order[i] = slot_order[pick];
      slot_order[pick] = tmp;
    end
    put(FUNC_CLEAR, 8'h00, '0);
    foreach (slot_order[i]) begin
      fill_pos[i] = 31'(slot_order[i] * 8_000_000 + $urandom_range(999, 0));
      put(FUNC_JOIN, 8'($urandom_range(255, 0)), fill_pos[i]);
    end
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_JOIN,  8'h5A, 31'd2_100_000_000);   // full: dropped
    put(FUNC_JOIN,  8'hC3, POS_MAX);             // full: dropped
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_JOIN,  8'hA5, fill_pos[5]);         // rename still works when full
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_LEAVE, 8'($urandom_range(255, 0)), '0);
    put(FUNC_JOIN,  8'hFF, POS_MAX);
    put(FUNC_QUERY, 8'h00, '0);
    put(FUNC_CLEAR, 8'h00, '0);
    put(FUNC_QUERY, 8'h00, '0);
  endtask

  // Stimulus sequence
  initial begin
    int unsigned idle_mix  [4] = '{0, 66, 0, 21};
    int unsigned stall_mix [4] = '{0, 0, 66, 21};
    in_t         it;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    wait_idle();
    fill_table();
    wait_idle();

    foreach (idle_mix[p]) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      repeat (PHASE_ITEMS) send_item(rand_item());
      wait_idle();

      // Long receiver hold-off with query-heavy traffic to back up the input
      if (p == 0) begin
        hold_reqs++;
        repeat (24) begin
          it = rand_item();
          if ($urandom_range(1, 0) == 1) it.func = FUNC_QUERY;
          send_item(it);
        end
        wait_idle();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (roster.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
